@@ rtl/hkst_pkg.sv @@
package hkst_pkg;

    localparam int unsigned HASH_LANES = 3;
    localparam logic [31:0] SEED_ONE_INIT = 32'h7FED7FED;
    localparam logic [31:0] SEED_TWO_INIT = 32'hEEEEEEEE;
    localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;
    localparam logic [47:0] TIME_MAX = 48'hFFFFFFFFFFFF;
    localparam logic [23:0] THRESH_RESET = 24'd100000;

    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] REG_THRESH_ADDR = 3'd0;

    typedef struct packed {
        logic [7:0]  key_char;
        logic        key_last;
        logic [23:0] response_time;
    } req_t;

    typedef struct packed {
        logic [5:0]  slot;
        logic        new_key;
        logic        table_full;
        logic [31:0] total_count;
        logic [31:0] timeout_count;
        logic [47:0] time_sum;
    } res_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] chk1;
        logic [31:0] chk2;
        logic [31:0] items;
        logic [31:0] touts;
        logic [47:0] tsum;
    } entry_t;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_MOD   = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_UPD   = 6'b100000
    } state_t;

endpackage

@@ rtl/hkst_hash.sv @@
module hkst_hash
    import hkst_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic                             restart,
    input  logic [7:0]                       ch,
    output logic [HASH_LANES-1:0][31:0]      hash
);

    logic [HASH_LANES-1:0][31:0] s1_reg, s2_reg;
    logic [HASH_LANES-1:0][31:0] s1_next, s2_next;
    logic [7:0]  cf;
    logic [31:0] cw;

    always_comb
    begin
        cf = ch;
        if (ch inside {[8'h61:8'h7A]})
        begin
            cf = ch - 8'h20;
        end
        cw = {24'd0, cf};
        for (int t = 0; t < HASH_LANES; t++)
        begin
            s1_next[t] = ((32'(t) << 8) + cw) ^ (s1_reg[t] + s2_reg[t]);
            s2_next[t] = cw + s1_next[t] + s2_reg[t] + (s2_reg[t] << 5) + 32'd3;
        end
    end

    assign hash = s1_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= {HASH_LANES{SEED_ONE_INIT}};
            s2_reg <= {HASH_LANES{SEED_TWO_INIT}};
        end
        else if (step)
        begin
            if (restart)
            begin
                s1_reg <= {HASH_LANES{SEED_ONE_INIT}};
                s2_reg <= {HASH_LANES{SEED_TWO_INIT}};
            end
            else
            begin
                s1_reg <= s1_next;
                s2_reg <= s2_next;
            end
        end
    end

endmodule

@@ rtl/hkst_mod.sv @@
module hkst_mod
    import hkst_pkg::*;
#(
    parameter int unsigned TABLE_SIZE = 64,
    parameter int unsigned IDX_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      dividend,
    output logic             done,
    output logic [IDX_W-1:0] result
);

    localparam bit POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
    localparam logic [31:0] MOD_C = 32'(TABLE_SIZE);
    // floor(2^32 / M): the quotient estimate is exact or one low
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_SIZE));

    logic             mul_reg, mul_next;
    logic             fix_reg, fix_next;
    logic             done_reg, done_next;
    logic [31:0]      x_reg, x_next;
    logic [31:0]      q_reg, q_next;
    logic [IDX_W-1:0] rem_reg, rem_next;
    logic [63:0]      prod;
    logic [31:0]      diff;

    always_comb
    begin
        mul_next  = 1'b0;
        fix_next  = 1'b0;
        done_next = 1'b0;
        x_next    = x_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        prod      = 64'(x_reg) * 64'(RECIP);
        diff      = x_reg - q_reg * MOD_C;
        if (start)
        begin
            if (POW2)
            begin
                rem_next  = dividend[IDX_W-1:0];
                done_next = 1'b1;
            end
            else
            begin
                x_next   = dividend;
                mul_next = 1'b1;
            end
        end
        if (mul_reg)
        begin
            q_next   = prod[63:32];
            fix_next = 1'b1;
        end
        if (fix_reg)
        begin
            if (diff >= MOD_C)
            begin
                rem_next = IDX_W'(diff - MOD_C);
            end
            else
            begin
                rem_next = IDX_W'(diff);
            end
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= mul_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

@@ rtl/hkst_table.sv @@
module hkst_table
    import hkst_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW = 6
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/hashed_key_stats_table.sv @@
// Key characters are taken one per cycle while busy is low; a character without
// key_last only steps the hash and gives no result. The last character sets busy
// and starts the lookup: hashes and response time are latched, hash0 is reduced
// to a slot (its low bits when TABLE_SIZE is a power of two, else a reciprocal
// multiply and a correction step), then each slot probed takes a read state and a
// check state (table memory read and compare, one read port) until an empty slot
// or a match; the updated entry is written back and the result strobe (done) is
// high for one cycle. If all TABLE_SIZE slots are probed without either, done
// reports table_full and nothing is written. Results cannot be stalled: capture res
// whenever done is high. After reset busy stays high while the table is cleared;
// configuration writes are taken at all times.
module hashed_key_stats_table
    import hkst_pkg::*;
#(
    parameter int unsigned TABLE_SIZE = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  req_t               req,
    output logic               done,
    output res_t               res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int unsigned SW = (IDX_W > 6) ? IDX_W : 6;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    state_t state_reg, state_next;

    logic [23:0] thresh_reg;
    logic        accept;

    logic [HASH_LANES-1:0][31:0] hash;
    logic             mod_done;
    logic [IDX_W-1:0] mod_result;

    logic             we, re;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata, rdata;

    logic [31:0]      h1_reg, h2_reg;
    logic [23:0]      rt_reg;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    entry_t           ent_reg, ent_next;
    logic             fresh_reg, fresh_next;
    logic             done_reg, done_next;
    res_t             res_reg, res_next;

    logic [SW-1:0] pos_ext;
    logic [31:0]   items_n, touts_n;
    logic [48:0]   tsum_w;
    logic [47:0]   tsum_n;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESH_ADDR[2]) ? {8'd0, thresh_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_THRESH_ADDR[2]))
        begin
            thresh_reg <= pwdata[23:0];
        end
    end

    hkst_hash u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .restart (req.key_last),
        .ch      (req.key_char),
        .hash    (hash)
    );

    hkst_mod #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && req.key_last),
        .dividend (hash[0]),
        .done     (mod_done),
        .result   (mod_result)
    );

    hkst_table #(
        .DEPTH (TABLE_SIZE),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (pos_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        items_n = (ent_reg.items == COUNT_MAX) ? ent_reg.items : ent_reg.items + 32'd1;
        touts_n = ent_reg.touts;
        if (rt_reg >= thresh_reg && ent_reg.touts != COUNT_MAX)
        begin
            touts_n = ent_reg.touts + 32'd1;
        end
        tsum_w = {1'b0, ent_reg.tsum} + {25'd0, rt_reg};
        tsum_n = (tsum_w > {1'b0, TIME_MAX}) ? TIME_MAX : tsum_w[47:0];
        pos_ext = SW'(pos_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        ent_next   = ent_reg;
        fresh_next = fresh_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = pos_reg;
        wdata      = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && req.key_last)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    pos_next   = mod_result;
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                re         = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!rdata.valid)
                begin
                    ent_next   = '0;
                    fresh_next = 1'b1;
                    state_next = ST_UPD;
                end
                else if (rdata.chk1 == h1_reg && rdata.chk2 == h2_reg)
                begin
                    ent_next   = rdata;
                    fresh_next = 1'b0;
                    state_next = ST_UPD;
                end
                else if (cnt_reg == LAST_IDX)
                begin
                    res_next            = '0;
                    res_next.table_full = 1'b1;
                    done_next           = 1'b1;
                    state_next          = ST_IDLE;
                end
                else
                begin
                    pos_next   = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_UPD:
            begin
                we          = 1'b1;
                wdata.valid = 1'b1;
                wdata.chk1  = h1_reg;
                wdata.chk2  = h2_reg;
                wdata.items = items_n;
                wdata.touts = touts_n;
                wdata.tsum  = tsum_n;
                res_next.slot          = pos_ext[5:0];
                res_next.new_key       = fresh_reg;
                res_next.table_full    = 1'b0;
                res_next.total_count   = items_n;
                res_next.timeout_count = touts_n;
                res_next.time_sum      = tsum_n;
                done_next              = 1'b1;
                state_next             = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && req.key_last)
        begin
            h1_reg <= hash[1];
            h2_reg <= hash[2];
            rt_reg <= req.response_time;
        end
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
        ent_reg   <= ent_next;
        fresh_reg <= fresh_next;
        res_reg   <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ rtl/hkst_checker.sv @@
module hkst_checker
    import hkst_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic done,
    input res_t res
);

    // a result only follows a lookup in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without lookup");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.table_full) |-> (res.slot == 6'd0 && !res.new_key &&
            res.total_count == 32'd0 && res.timeout_count == 32'd0 &&
            res.time_sum == 48'd0))
        else $error("full-table result carries data");

    a_new_first: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.new_key) |-> (res.total_count == 32'd1 && !res.table_full &&
            res.time_sum < 48'h1000000))
        else $error("new key with stale counters");

    a_touts_le_items: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !res.table_full) |-> (res.timeout_count <= res.total_count &&
            res.total_count != 32'd0))
        else $error("timeout count above item count");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back results");

endmodule

bind hashed_key_stats_table hkst_checker u_hkst_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (busy),
    .done  (done),
    .res   (res)
);
